### design/vn_pkg.sv
// Shared types for the vector normalizer pipeline.
package vn_pkg;

    // Pipeline flow control that the top level hands to every stage group.
    typedef struct packed {
        logic adv;
    } t_pipe_ctl;

endpackage

### design/vn_lane.sv
// One component lane: absolute value, square and threshold test.
module vn_lane
    import vn_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  t_pipe_ctl           i_ctl,
    input  logic signed [W-1:0] i_comp,
    input  logic [W-2:0]        i_thr,
    output logic [W-1:0]        o_mag,
    output logic                o_neg,
    output logic [2*W-1:0]      o_sq,
    output logic                o_small
);

    logic [W-1:0] n_mag;
    logic [W-1:0] r_mag;
    logic         r_neg;
    logic [2*W-1:0] r_sq;
    logic         r_small;

    // The most negative value wraps to 2^(W-1), which is its true magnitude.
    assign n_mag = i_comp[W-1] ? (~i_comp + 1'b1) : i_comp;

    // Register magnitude, sign, square and the small test together.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_mag   <= n_mag;
            r_neg   <= i_comp[W-1];
            r_sq    <= n_mag * n_mag;
            r_small <= (n_mag <= {1'b0, i_thr});
        end
    end

    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_sq    = r_sq;
    assign o_small = r_small;

endmodule

### design/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  t_pipe_ctl      i_ctl,
    input  logic [2*W-1:0] i_rad,
    output logic [W-1:0]   o_root
);

    logic [2*W-1:0] r_rad  [W];
    logic [W+1:0]   r_rem  [W];
    logic [W-1:0]   r_root [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [2*W-1:0] rad_in;
        logic [W+1:0]   rem_in;
        logic [W-1:0]   root_in;
        logic [W+3:0]   rem_sh;
        logic [W+3:0]   trial;
        logic           ge;

        // Stage inputs come from the radicand for the first stage.
        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign rem_sh = {rem_in, rad_in[2*W-1:2*W-2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rad[k]  <= {rad_in[2*W-3:0], 2'b00};
                r_rem[k]  <= ge ? (W+2)'(rem_sh - trial) : rem_sh[W+1:0];
                r_root[k] <= {root_in[W-2:0], ge};
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule

### design/vn_div.sv
// One divider lane: restoring fractional division of a magnitude by the length.
module vn_div
    import vn_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic        i_clk,
    input  t_pipe_ctl   i_ctl,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    input  logic        i_neg,
    output logic [F+1:0] o_unit
);

    localparam int NS = F + 1;

    logic [W:0]   r_rem [NS];
    logic [F:0]   r_quo [NS];
    logic [W-1:0] r_den [NS];
    logic         r_neg [NS];
    logic [F+1:0] quo_ext;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [W:0]   rem_in;
        logic [F:0]   quo_in;
        logic [W-1:0] den_in;
        logic         neg_in;
        logic         ge;

        // The first stage tests the integer bit, later stages one fraction bit.
        if (k == 0) begin : g_first
            assign rem_in = {1'b0, i_num};
            assign quo_in = '0;
            assign den_in = i_den;
            assign neg_in = i_neg;
        end else begin : g_next
            assign rem_in = {r_rem[k-1][W-1:0], 1'b0};
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign neg_in = r_neg[k-1];
        end

        assign ge = (rem_in >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[k] <= ge ? (rem_in - {1'b0, den_in}) : rem_in;
                r_quo[k] <= {quo_in[F-1:0], ge};
                r_den[k] <= den_in;
                r_neg[k] <= neg_in;
            end
        end
    end

    // Apply the sign; a zero length forces the component to zero.
    assign quo_ext = {1'b0, r_quo[NS-1]};
    assign o_unit  = (r_den[NS-1] == '0) ? '0 :
                     r_neg[NS-1] ? (~quo_ext + 1'b1) : quo_ext;

endmodule

### design/vector3_normalize.sv
// Vector normalizer top level: lanes, root, divider lanes and output register.
// Takes one signed fixed-point 3D vector per cycle and returns its floored
// length, the unit vector truncated toward zero and the zero-length and
// all-small flags. The pipeline runs through the squaring lanes, the
// bit-per-stage square root, the divider lanes and the output register, in
// that order. A new word is taken every cycle; the whole pipeline holds
// while a finished word waits unread.
module vector3_normalize
    import vn_pkg::*;
#(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [COMP_WIDTH-2:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    input  logic signed [COMP_WIDTH-1:0] i_comp_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [FRAC_BITS+1:0]  o_unit_x,
    output logic signed [FRAC_BITS+1:0]  o_unit_y,
    output logic signed [FRAC_BITS+1:0]  o_unit_z,
    output logic [COMP_WIDTH-1:0]        o_magnitude,
    output logic                         o_zero_length,
    output logic                         o_all_small
);

    localparam int W  = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SQ = W;
    localparam int DV = F + 1;

    t_pipe_ctl ctl;
    logic [W-2:0] r_thr;
    logic         r_v0;

    logic [W-1:0]   mag [3];
    logic           neg [3];
    logic [2*W-1:0] sq  [3];
    logic           is_small [3];
    logic [W-1:0]   root;
    logic [F+1:0]   unit [3];

    // Side data that rides along the square root stages.
    logic         r_sv   [SQ];
    logic [W-1:0] r_smag [SQ][3];
    logic         r_sneg [SQ][3];
    logic         r_ssml [SQ];
    // Side data that rides along the divider stages.
    logic         r_dv   [DV];
    logic [W-1:0] r_droot[DV];
    logic         r_dsml [DV];

    logic               r_out_valid;
    logic [F+1:0]       r_unit [3];
    logic [W-1:0]       r_mag_out;
    logic               r_zero;
    logic               r_small_out;

    // The pipeline moves whenever the output register is free or being read.
    assign ctl.adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = ctl.adv;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Component lanes.
    vn_lane #(.W(W)) u_lane_x (.i_clk(i_clk), .i_ctl(ctl), .i_comp(i_comp_x),
        .i_thr(r_thr), .o_mag(mag[0]), .o_neg(neg[0]), .o_sq(sq[0]),
        .o_small(is_small[0]));
    vn_lane #(.W(W)) u_lane_y (.i_clk(i_clk), .i_ctl(ctl), .i_comp(i_comp_y),
        .i_thr(r_thr), .o_mag(mag[1]), .o_neg(neg[1]), .o_sq(sq[1]),
        .o_small(is_small[1]));
    vn_lane #(.W(W)) u_lane_z (.i_clk(i_clk), .i_ctl(ctl), .i_comp(i_comp_z),
        .i_thr(r_thr), .o_mag(mag[2]), .o_neg(neg[2]), .o_sq(sq[2]),
        .o_small(is_small[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (ctl.adv) begin
            r_v0 <= i_in_valid;
        end
    end

    // Merge: the sum of squares feeds the root pipeline.
    vn_sqrt #(.W(W)) u_sqrt (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_rad (sq[0] + sq[1] + sq[2]),
        .o_root(root)
    );

    // Delay line matching the root pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (ctl.adv) begin
            r_sv[0] <= r_v0;
            for (int k = 1; k < SQ; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            r_ssml[0] <= is_small[0] && is_small[1] && is_small[2];
            for (int j = 0; j < 3; j++) begin
                r_smag[0][j] <= mag[j];
                r_sneg[0][j] <= neg[j];
            end
            for (int k = 1; k < SQ; k++) begin
                r_ssml[k] <= r_ssml[k-1];
                for (int j = 0; j < 3; j++) begin
                    r_smag[k][j] <= r_smag[k-1][j];
                    r_sneg[k][j] <= r_sneg[k-1][j];
                end
            end
        end
    end

    // Divider lanes.
    for (genvar j = 0; j < 3; j++) begin : g_div
        vn_div #(.W(W), .F(F)) u_div (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_num (r_smag[SQ-1][j]),
            .i_den (root),
            .i_neg (r_sneg[SQ-1][j]),
            .o_unit(unit[j])
        );
    end

    // Delay line matching the divider pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DV; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (ctl.adv) begin
            r_dv[0] <= r_sv[SQ-1];
            for (int k = 1; k < DV; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            r_droot[0] <= root;
            r_dsml[0]  <= r_ssml[SQ-1];
            for (int k = 1; k < DV; k++) begin
                r_droot[k] <= r_droot[k-1];
                r_dsml[k]  <= r_dsml[k-1];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.adv) begin
            r_out_valid <= r_dv[DV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv) begin
            for (int j = 0; j < 3; j++) begin
                r_unit[j] <= unit[j];
            end
            r_mag_out   <= r_droot[DV-1];
            r_zero      <= (r_droot[DV-1] == '0);
            r_small_out <= r_dsml[DV-1];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_magnitude   = r_mag_out;
    assign o_zero_length = r_zero;
    assign o_all_small   = r_small_out;

endmodule
